// ===== sv/pds_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pds_pkg
// Shared widths, constants and controller/datapath interface types for the
// PLL divider search unit.
// ----------------------------------------------------------------------------
package pds_pkg;

	localparam int REF_W       = 14;
	localparam int TGT_W       = 22;
	localparam int DIV_M_W     = 6;
	localparam int MULT_N_W    = 8;
	localparam int POST_K_W    = 2;
	localparam int FREQ_W      = 22;
	localparam int CTRL_WORD_W = 16;
	localparam int ERR_W       = 22;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_FIELD_W = DIV_M_W + MULT_N_W + POST_K_W + FREQ_W + CTRL_WORD_W + ERR_W;
	localparam int OUT_TDATA_W = 80;

	localparam logic [REF_W-1:0] REF_RESET = 14'd14318;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;     // load target, clear best, rewind the M/N counters
		logic issue;     // push the current (M,N) pair into the pipeline
		logic load_out;  // copy the best setting into the result register
	} pds_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_pair; // counters sit on the final (M,N) pair
		logic busy;      // some pair is still in flight
	} pds_sts_t;

endpackage
`default_nettype wire

// ===== sv/pds_div_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pds_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with a tag that
// travels alongside each operand pair.
// ----------------------------------------------------------------------------
module pds_div_pipe #(
	parameter int NUM_W = 23,
	parameter int DEN_W = 7,
	parameter int TAG_W = 14
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_vld,
	input  wire logic [NUM_W-1:0] in_num,
	input  wire logic [DEN_W-1:0] in_den,
	input  wire logic [TAG_W-1:0] in_tag,
	output logic                  out_vld,
	output logic [NUM_W-1:0]      out_quo,
	output logic [TAG_W-1:0]      out_tag,
	output logic                  busy
);

	// Each stage holds the partly shifted numerator (quotient bits enter at
	// the bottom as dividend bits leave the top) and the running remainder.
	logic [NUM_W-1:0] vld_s;
	logic [NUM_W-1:0] num_s [NUM_W];
	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];
	logic [TAG_W-1:0] tag_s [NUM_W];

	logic             vld_in [NUM_W];
	logic [NUM_W-1:0] num_in [NUM_W];
	logic [DEN_W-1:0] rem_in [NUM_W];
	logic [DEN_W-1:0] den_in [NUM_W];
	logic [TAG_W-1:0] tag_in [NUM_W];

	assign vld_in[0] = in_vld;
	assign num_in[0] = in_num;
	assign rem_in[0] = '0;
	assign den_in[0] = in_den;
	assign tag_in[0] = in_tag;

	for (genvar j = 1; j < NUM_W; j++) begin : g_link
		assign vld_in[j] = vld_s[j-1];
		assign num_in[j] = num_s[j-1];
		assign rem_in[j] = rem_s[j-1];
		assign den_in[j] = den_s[j-1];
		assign tag_in[j] = tag_s[j-1];
	end

	for (genvar j = 0; j < NUM_W; j++) begin : g_stage
		logic [DEN_W:0] shifted;
		logic           fits;

		assign shifted = {rem_in[j], num_in[j][NUM_W-1]};
		assign fits    = shifted >= {1'b0, den_in[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else begin
				vld_s[j] <= vld_in[j];
			end
		end

		always_ff @(posedge clk) begin
			if (fits) begin
				rem_s[j] <= DEN_W'(shifted - {1'b0, den_in[j]});
			end else begin
				rem_s[j] <= shifted[DEN_W-1:0];
			end
			num_s[j] <= {num_in[j][NUM_W-2:0], fits};
			den_s[j] <= den_in[j];
			tag_s[j] <= tag_in[j];
		end
	end

	assign out_vld = vld_s[NUM_W-1];
	assign out_quo = num_s[NUM_W-1];
	assign out_tag = tag_s[NUM_W-1];
	assign busy    = |vld_s;

endmodule
`default_nettype wire

// ===== sv/pds_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pds_datapath
// M/N enumeration, product stage, divider pipeline, per-K error stage and
// best-setting tracking, plus the reference register and result register.
// ----------------------------------------------------------------------------
module pds_datapath
	import pds_pkg::*;
#(
	parameter int M_COUNT = 64,
	parameter int N_COUNT = 256,
	parameter int K_COUNT = 4
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [REF_W-1:0]       cfg_wdata,
	input  wire logic [TGT_W-1:0]       in_target,
	input  wire pds_cmd_t               cmd,
	output pds_sts_t                    sts,
	output logic [OUT_TDATA_W-1:0]      out_data,
	output logic                        out_found
);

	localparam int MW   = $clog2(M_COUNT);
	localparam int NW   = $clog2(N_COUNT);
	localparam int KW   = (K_COUNT > 1) ? $clog2(K_COUNT) : 1;
	localparam int DW   = $clog2(M_COUNT + 2);
	localparam int NPW  = $clog2(N_COUNT + 2);
	localparam int PW   = REF_W + NPW;
	localparam int FW   = (PW > TGT_W) ? PW : TGT_W;
	localparam int TAGW = MW + NW;

	logic [REF_W-1:0] ref_q;
	logic [TGT_W-1:0] target_q;
	logic [MW-1:0]    m_cnt_q;
	logic [NW-1:0]    n_cnt_q;
	logic             m_last;
	logic             n_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= REF_RESET;
		end else if (cfg_we) begin
			ref_q <= cfg_wdata;
		end
	end

	assign m_last = m_cnt_q == MW'(M_COUNT - 1);
	assign n_last = n_cnt_q == NW'(N_COUNT - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_cnt_q <= '0;
			n_cnt_q <= '0;
		end else if (cmd.start) begin
			m_cnt_q <= '0;
			n_cnt_q <= '0;
		end else if (cmd.issue) begin
			if (n_last) begin
				n_cnt_q <= '0;
				m_cnt_q <= m_cnt_q + MW'(1);
			end else begin
				n_cnt_q <= n_cnt_q + NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			target_q <= in_target;
		end
	end

	// Product stage: ref * (N + 2) and divisor M + 2.
	logic             vld_s1;
	logic [PW-1:0]    prod_s1;
	logic [DW-1:0]    den_s1;
	logic [TAGW-1:0]  tag_s1;
	logic [NPW-1:0]   n_plus2;

	assign n_plus2 = NPW'(n_cnt_q) + NPW'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(ref_q) * PW'(n_plus2);
		den_s1  <= DW'(m_cnt_q) + DW'(2);
		tag_s1  <= {m_cnt_q, n_cnt_q};
	end

	logic            dv_vld;
	logic [PW-1:0]   dv_quo;
	logic [TAGW-1:0] dv_tag;
	logic            dv_busy;

	pds_div_pipe #(
		.NUM_W (PW),
		.DEN_W (DW),
		.TAG_W (TAGW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s1),
		.in_num  (prod_s1),
		.in_den  (den_s1),
		.in_tag  (tag_s1),
		.out_vld (dv_vld),
		.out_quo (dv_quo),
		.out_tag (dv_tag),
		.busy    (dv_busy)
	);

	// Error stage: one subtractor per post divider setting.
	logic [FW-1:0]   tgt_ext;
	logic [FW-1:0]   kerr_d  [K_COUNT];
	logic [FW-1:0]   kerr_s2 [K_COUNT];
	logic            vld_s2;
	logic [PW-1:0]   quo_s2;
	logic [TAGW-1:0] tag_s2;

	assign tgt_ext = FW'(target_q);

	always_comb begin
		logic [FW-1:0] fk;
		for (int k = 0; k < K_COUNT; k++) begin
			fk        = FW'(dv_quo) >> k;
			kerr_d[k] = (fk >= tgt_ext) ? fk - tgt_ext : tgt_ext - fk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		kerr_s2 <= kerr_d;
		quo_s2  <= dv_quo;
		tag_s2  <= dv_tag;
	end

	// Lowest error over K, the earliest K winning ties, as a sequential scan would.
	logic [KW-1:0] sel_k;
	logic [FW-1:0] sel_err;
	logic          take;

	always_comb begin
		sel_k   = '0;
		sel_err = kerr_s2[0];
		for (int k = 1; k < K_COUNT; k++) begin
			if (kerr_s2[k] < sel_err) begin
				sel_k   = KW'(k);
				sel_err = kerr_s2[k];
			end
		end
	end

	logic [FW-1:0] best_err_q;
	logic [FW-1:0] best_f_q;
	logic [MW-1:0] best_m_q;
	logic [NW-1:0] best_n_q;
	logic [KW-1:0] best_k_q;
	logic          hit_q;

	assign take = vld_s2 && (sel_err < best_err_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.start) begin
			hit_q <= 1'b0;
		end else if (take) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_err_q <= FW'(in_target);
			best_f_q   <= '0;
			best_m_q   <= '0;
			best_n_q   <= '0;
			best_k_q   <= '0;
		end else if (take) begin
			best_err_q <= sel_err;
			best_f_q   <= FW'(quo_s2) >> sel_k;
			best_m_q   <= tag_s2[TAGW-1:NW];
			best_n_q   <= tag_s2[NW-1:0];
			best_k_q   <= sel_k;
		end
	end

	// Result register.
	logic [CTRL_WORD_W-1:0] ctrl_word;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic                   out_found_q;

	assign ctrl_word = (CTRL_WORD_W'(best_n_q) << 8) | (CTRL_WORD_W'(best_m_q) << 2)
		| CTRL_WORD_W'(best_k_q);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_found_q <= hit_q;
			if (hit_q) begin
				out_data_q <= {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}},
					ERR_W'(best_err_q), ctrl_word, FREQ_W'(best_f_q),
					POST_K_W'(best_k_q), MULT_N_W'(best_n_q), DIV_M_W'(best_m_q)};
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign out_data      = out_data_q;
	assign out_found     = out_found_q;
	assign sts.last_pair = m_last && n_last;
	assign sts.busy      = vld_s1 || dv_busy || vld_s2;

	a_best_below_target: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> best_err_q < FW'(target_q))
		else $error("best error not below target");

	a_best_never_grows: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !cmd.start |=> best_err_q <= $past(best_err_q))
		else $error("best error grew during sweep");

endmodule
`default_nettype wire

// ===== sv/pds_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pds_ctrl
// Sequencer for one search: accept the target, sweep all (M,N) pairs, drain
// the pipeline, then hand the best setting to the result register.
// ----------------------------------------------------------------------------
module pds_ctrl
	import pds_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  wire logic     m_tready,
	output pds_cmd_t      cmd,
	input  wire pds_sts_t sts
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SWEEP  = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   m_tvalid_q;
	logic   out_free;

	// The result register may be refilled in the cycle its beat leaves.
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d      = state_q;
		cmd.start    = 1'b0;
		cmd.issue    = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.start = 1'b1;
					state_d   = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				cmd.issue = 1'b1;
				if (sts.last_pair) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;

	a_rise_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.load_out))
		else $error("result beat without a load");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !sts.busy)
		else $error("pipeline not empty while idle");

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !sts.busy)
		else $error("result loaded while pairs in flight");

	a_start_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> state_q == ST_SWEEP && !sts.busy)
		else $error("search start did not enter sweep");

endmodule
`default_nettype wire

// ===== sv/pll_divider_search_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pll_divider_search_unit
// Searches all PLL M/N/K settings for the one closest to a target frequency.
// ----------------------------------------------------------------------------
//  channel  signals                      beat contents
//  in       s_tvalid/s_tready/s_tdata    target_khz
//  out      m_tvalid/m_tready/m_tdata    div_m, mult_n, post_k, achieved_khz,
//           m_tuser                      control_word, error_khz; found
//  config   cfg_we/cfg_wdata             ref_clock_khz
//
//  One search sweeps all M_COUNT*N_COUNT (M,N) pairs: one pair enters the
//  divider pipeline per cycle and all K post divider settings are judged in
//  parallel behind it.
//  One target is worked on at a time; a new one is taken while the last
//  result still waits in the output register.
//  Reset sets ref_clock_khz to 14318 and empties the pipeline and output.
// ----------------------------------------------------------------------------
module pll_divider_search_unit
	import pds_pkg::*;
#(
	parameter int M_COUNT = 64,
	parameter int N_COUNT = 256,
	parameter int K_COUNT = 4
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [REF_W-1:0]       cfg_wdata,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [21:0] target_khz
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,   // [5:0] div_m, [13:6] mult_n,
	                                               // [15:14] post_k, [37:16] achieved_khz,
	                                               // [53:38] control_word, [75:54] error_khz
	output logic [0:0]                  m_tuser    // [0] found
);

	pds_cmd_t cmd;
	pds_sts_t sts;
	logic     found;

	pds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	pds_datapath #(
		.M_COUNT (M_COUNT),
		.N_COUNT (N_COUNT),
		.K_COUNT (K_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_target (s_tdata[TGT_W-1:0]),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (m_tdata),
		.out_found (found)
	);

	assign m_tuser = found;

endmodule
`default_nettype wire
